[sv/lie_pkg.sv]
// lie_pkg: shared types and constants for the lagrange interpolation evaluator
// no dependencies
package lie_pkg;
    localparam int MaxNodes = 16;
    localparam int IdxW     = 4;
    localparam int CntW     = 5;

    localparam logic       CmdLoad  = 1'b0;
    localparam logic       CmdEval  = 1'b1;
    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StDup    = 2'd1;
    localparam logic [1:0] StOvf    = 2'd2;

    localparam logic signed [31:0] QOne = 32'sh0001_0000;

    typedef struct packed {
        logic        command;
        logic [3:0]  entry_index;
        logic [31:0] node_position;
        logic [31:0] node_sample;
        logic [31:0] query_x;
    } t_in;

    typedef struct packed {
        logic [31:0] interpolated_value;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;
endpackage

[sv/lie_if.sv]
// lie_in_if, lie_out_if, lie_cfg_if: valid/ready channels
// depends on lie_pkg
interface lie_in_if;
    logic         valid;
    logic         ready;
    lie_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lie_out_if;
    logic          valid;
    logic          ready;
    lie_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lie_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/lie_div.sv]
// lie_div: radix-2 restoring divider, 49-bit numerator by 34-bit divisor
// rounds half away from zero by adding half the divisor; depends on lie_pkg
module lie_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lie_pkg::t_div_req    i_req,
    input  logic [48:0]          i_num,
    input  logic [33:0]          i_den,
    output logic                 o_done,
    output logic                 o_neg,
    output logic [49:0]          o_quo
);
    logic [49:0] r_q;
    logic [34:0] r_rem;
    logic [33:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_neg;
    logic [34:0] n_trial;
    logic [34:0] n_shift;

    assign n_shift = {r_rem[33:0], r_q[49]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd50;
                r_q    <= {1'b0, i_num} + {17'd0, i_den[33:1]};
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_req.neg;
            end else if (r_busy) begin
                if (!n_trial[34]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[48:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[48:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_neg  = r_neg;
    assign o_quo  = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without work");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> (r_busy == i_req.start || $past(i_req.start)) || !r_busy)
        else $error("divider started spuriously");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_req.start |=> r_busy || r_done)
        else $error("divider stopped early");
endmodule

[sv/lagrange_interpolation_eval_top.sv]
// lagrange_interpolation_eval_top: evaluator of a lagrange polynomial in Q16.16
// depends on lie_pkg, lie_if (interfaces) and lie_div
//
// Channels: s_in carries load and evaluate commands, m_out carries one beat
// per evaluate, s_cfg writes node_count (5 bits, reset 1).
// A load beat stores position and sample in its slot; s_in.ready stays
// high, as the block stays idle.
// An evaluate over n nodes first compares all pairs, one pair per cycle,
// then for each i and each t != i runs one quotient on the shared serial
// divider, with a select step before it and a basis multiply after it,
// then a sample multiply and a saturating add per i; the result is then
// registered for m_out. Duplicate positions end the evaluate as soon as
// the equal pair is found.
// One command is handled at a time; s_in.ready is low while an evaluate runs.
// A result waits in the output register while m_out stalls; a following
// evaluate holds in its last step until that result is taken.
// Reset clears control state and sets node_count to 1; node stores hold
// nothing defined until loaded.
module lagrange_interpolation_eval_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lie_in_if.sink    s_in,
    lie_out_if.source m_out,
    lie_cfg_if.sink   s_cfg
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DUP   = 8'b0000_0010,
        S_TSEL  = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_BMUL  = 8'b0001_0000,
        S_SMUL  = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic signed [31:0] r_pos [lie_pkg::MaxNodes];
    logic signed [31:0] r_smp [lie_pkg::MaxNodes];
    logic [4:0]  r_cnt;
    logic [4:0]  r_n;
    logic [3:0]  r_i;
    logic [3:0]  r_t;
    logic signed [31:0] r_x;
    logic signed [31:0] r_basis;
    logic signed [31:0] r_sum;
    logic signed [31:0] r_q;
    logic        r_ovf;
    logic        r_dup;
    logic        r_wait;
    lie_pkg::t_out r_out;
    logic        r_ovalid;

    lie_pkg::t_div_req n_req;
    logic signed [33:0] n_num;
    logic signed [33:0] n_den;
    logic        d_done;
    logic        d_neg;
    logic [49:0] d_quo;

    logic signed [31:0] n_ma;
    logic signed [31:0] n_mb;
    logic [31:0] n_amag;
    logic [31:0] n_bmag;
    logic [63:0] n_prod;
    logic [48:0] n_pr;
    logic        n_pneg;
    logic signed [31:0] n_mres;
    logic        n_movf;
    logic signed [31:0] n_dres;
    logic        n_dovf;
    logic signed [32:0] n_add;
    logic [4:0]  n_eff;
    logic        n_ofree;

    assign s_cfg.ready = (r_state == S_IDLE);
    assign s_in.ready  = (r_state == S_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.payload = r_out;
    assign n_ofree = !r_ovalid || m_out.ready;

    assign n_eff = (r_cnt > 5'(lie_pkg::MaxNodes)) ? 5'(lie_pkg::MaxNodes) : r_cnt;

    assign n_num = 34'(r_x) - 34'(r_pos[r_t]);
    assign n_den = 34'(r_pos[r_i]) - 34'(r_pos[r_t]);
    assign n_req.start = (r_state == S_TSEL) && (r_t != r_i) && !r_wait;
    assign n_req.neg   = n_num[33] ^ n_den[33];

    lie_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_req),
        .i_num  ({(n_num[33] ? 33'(-n_num) : 33'(n_num)), 16'd0}),
        .i_den  (n_den[33] ? 34'(-n_den) : n_den),
        .o_done (d_done),
        .o_neg  (d_neg),
        .o_quo  (d_quo)
    );

    always_comb begin
        if (d_quo == '0) begin
            n_dres = '0;
            n_dovf = 1'b0;
        end else if (d_neg) begin
            n_dovf = d_quo > 50'h8000_0000;
            n_dres = n_dovf ? 32'sh8000_0000 : 32'(-d_quo);
        end else begin
            n_dovf = d_quo > 50'h7FFF_FFFF;
            n_dres = n_dovf ? 32'sh7FFF_FFFF : 32'(d_quo);
        end
    end

    // shared multiplier
    assign n_ma   = (r_state == S_SMUL) ? r_smp[r_i] : r_basis;
    assign n_mb   = (r_state == S_SMUL) ? r_basis : r_q;
    assign n_amag = n_ma[31] ? 32'(-n_ma) : 32'(n_ma);
    assign n_bmag = n_mb[31] ? 32'(-n_mb) : 32'(n_mb);
    assign n_prod = {32'd0, n_amag} * {32'd0, n_bmag};
    assign n_pr   = 49'((65'(n_prod) + 65'h8000) >> 16);
    assign n_pneg = (n_ma[31] ^ n_mb[31]) && (n_pr != '0);

    always_comb begin
        if (n_pneg) begin
            n_movf = n_pr > 49'h8000_0000;
            n_mres = n_movf ? 32'sh8000_0000 : 32'(-n_pr);
        end else begin
            n_movf = n_pr > 49'h7FFF_FFFF;
            n_mres = n_movf ? 32'sh7FFF_FFFF : 32'(n_pr);
        end
    end

    assign n_add = 33'(r_sum) + 33'(r_q);

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready && s_in.payload.command == lie_pkg::CmdLoad) begin
            r_pos[s_in.payload.entry_index] <= s_in.payload.node_position;
            r_smp[s_in.payload.entry_index] <= s_in.payload.node_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 5'd1;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            if (s_cfg.valid && s_cfg.ready) r_cnt <= s_cfg.data;
            case (r_state)
                S_IDLE: begin
                    if (s_in.valid && s_in.ready &&
                        s_in.payload.command == lie_pkg::CmdEval) begin
                        r_x   <= s_in.payload.query_x;
                        r_n   <= n_eff;
                        r_i   <= '0;
                        r_t   <= 4'd1;
                        r_sum <= '0;
                        r_ovf <= 1'b0;
                        r_dup <= 1'b0;
                        r_state <= S_DUP;
                    end
                end
                S_DUP: begin
                    if (n_eff <= 5'd1 || 5'(r_i) >= r_n - 5'd1) begin
                        r_i <= '0;
                        r_t <= '0;
                        r_basis <= lie_pkg::QOne;
                        r_state <= (r_n == 5'd0) ? S_OUT : S_TSEL;
                    end else if (r_pos[r_i] == r_pos[r_t]) begin
                        r_sum   <= '0;
                        r_dup   <= 1'b1;
                        r_state <= S_OUT;
                    end else if (5'(r_t) == r_n - 5'd1) begin
                        r_i <= r_i + 4'd1;
                        r_t <= r_i + 4'd2;
                    end else begin
                        r_t <= r_t + 4'd1;
                    end
                end
                S_TSEL: begin
                    if (5'(r_t) >= r_n) begin
                        r_state <= S_SMUL;
                    end else if (r_t == r_i) begin
                        r_t <= r_t + 4'd1;
                        if (5'(r_t) == r_n - 5'd1) r_state <= S_SMUL;
                    end else begin
                        r_wait  <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (d_done) begin
                        r_wait <= 1'b0;
                        r_q    <= n_dres;
                        r_ovf  <= r_ovf | n_dovf;
                        r_state <= S_BMUL;
                    end
                end
                S_BMUL: begin
                    r_basis <= n_mres;
                    r_ovf   <= r_ovf | n_movf;
                    r_state <= (5'(r_t) == r_n - 5'd1) ? S_SMUL : S_TSEL;
                    r_t     <= r_t + 4'd1;
                end
                S_SMUL: begin
                    r_q     <= n_mres;
                    r_ovf   <= r_ovf | n_movf;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (n_add > 33'sh0_7FFF_FFFF) begin
                        r_sum <= 32'sh7FFF_FFFF;
                        r_ovf <= 1'b1;
                    end else if (n_add < -33'sh0_8000_0000) begin
                        r_sum <= 32'sh8000_0000;
                        r_ovf <= 1'b1;
                    end else begin
                        r_sum <= 32'(n_add);
                    end
                    r_basis <= lie_pkg::QOne;
                    r_t     <= '0;
                    if (5'(r_i) == r_n - 5'd1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + 4'd1;
                        r_state <= S_TSEL;
                    end
                end
                S_OUT: begin
                    if (n_ofree) begin
                        r_out.interpolated_value <= r_sum;
                        r_out.status <= r_dup ? lie_pkg::StDup :
                                        (r_ovf ? lie_pkg::StOvf : lie_pkg::StOk);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_out.ready |=> r_ovalid && $stable(r_out))
        else $error("result overwritten");
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_done |-> r_state == S_DIV)
        else $error("quotient arrived outside divide step");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_in.ready)
        else $error("ready while busy");
endmodule
